/* hdl/tm_score_accumulator_defines.svh */
// assertion macros for the score accumulator
`ifndef TM_SCORE_ACCUMULATOR_DEFINES_SVH
`define TM_SCORE_ACCUMULATOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TMSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define TMSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/tmsa_pkg.sv */
// shared types and constants of the score accumulator
package tmsa_pkg;

  localparam int COORD_WIDTH_DEF = 20;
  localparam int ROT_W           = 18;
  localparam int TRANS_W         = 20;
  localparam int MUL_W           = 33;
  localparam int DIV_W           = 64;
  localparam int QUO_W           = 18;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 60;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  localparam logic [CFG_IDX_W-1:0] CFG_ROT_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DSCALE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NORM   = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_ACC, ST_DIFF, ST_SQ, ST_DADD, ST_D0, ST_DEN,
    ST_TDIV, ST_SUM, ST_FST, ST_FDIV, ST_OUT
  } state_t;

  typedef enum logic [1:0] {MS_ROT, MS_SQ, MS_D0} mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic [1:0] row;
    logic [1:0] col;
    logic     acc_en;
    logic     acc_clr;
    logic     diff_en;
    logic     dadd_en;
    logic     div_start;
    logic     div_final;
    logic     sum_en;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic last;
    logic out_busy;
  } status_t;

endpackage

/* hdl/tm_score_accumulator.sv */
// top level of the score accumulator
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_stall   first_x/y/z, second_x/y/z, last_pair
//  out      output     out_valid / out_stall tm_score, pair_count
//  cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// an item uses the one shared multiplier (nine
// rotation products, three squares, d0 squared) and the 18-step divider
// an item marked last also goes through the final divide and delivery
// reset is synchronous, no clearing pass is needed
// a result waits in the output register while out_stall is high
module tm_score_accumulator
  import tmsa_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_first_x,
  input  logic signed [COORD_WIDTH-1:0] in_first_y,
  input  logic signed [COORD_WIDTH-1:0] in_first_z,
  input  logic signed [COORD_WIDTH-1:0] in_second_x,
  input  logic signed [COORD_WIDTH-1:0] in_second_y,
  input  logic signed [COORD_WIDTH-1:0] in_second_z,
  input  logic                          in_last_pair,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [16:0]                   out_tm_score,
  output logic [15:0]                   out_pair_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  tmsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  tmsa_dp #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_first_x     (in_first_x),
    .in_first_y     (in_first_y),
    .in_first_z     (in_first_z),
    .in_second_x    (in_second_x),
    .in_second_y    (in_second_y),
    .in_second_z    (in_second_z),
    .in_last_pair   (in_last_pair),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_tm_score   (out_tm_score),
    .out_pair_count (out_pair_count)
  );

endmodule

/* hdl/tmsa_div.sv */
// radix-2 restoring divider, quotient saturated at one in Q1.16
`include "tm_score_accumulator_defines.svh"
module tmsa_div
  import tmsa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output logic             done,
  output logic [16:0]      quo
);

  localparam int DV_W = DIV_W + QUO_W - 1;

  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DV_W-1:0]  dv_r, dv_nxt;
  logic [QUO_W-1:0] q_r, q_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             ge;

  assign ge = {{(QUO_W-1){1'b0}}, rem_r} >= dv_r;

  always_comb begin
    rem_nxt  = rem_r;
    dv_nxt   = dv_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num;
      dv_nxt   = {den, {(QUO_W-1){1'b0}}};
      q_nxt    = '0;
      cnt_nxt  = 5'(QUO_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - dv_r[DIV_W-1:0];
      end
      q_nxt   = {q_r[QUO_W-2:0], ge};
      dv_nxt  = dv_r >> 1;
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo  = (q_r[QUO_W-1] || (q_r[16:0] > ONE_Q16)) ? ONE_Q16 : q_r[16:0];

  `TMSA_ASSERT_NEXT(a_div_start_busy, start, busy_r && !done_r, "divider did not start")

endmodule

/* hdl/tmsa_dp.sv */
// datapath: config registers, shared multiplier, accumulators, output register
`include "tm_score_accumulator_defines.svh"
module tmsa_dp
  import tmsa_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cmd_t                          cmd,
  output status_t                       status,
  input  logic                          cfg_valid,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic signed [COORD_WIDTH-1:0] in_first_x,
  input  logic signed [COORD_WIDTH-1:0] in_first_y,
  input  logic signed [COORD_WIDTH-1:0] in_first_z,
  input  logic signed [COORD_WIDTH-1:0] in_second_x,
  input  logic signed [COORD_WIDTH-1:0] in_second_y,
  input  logic signed [COORD_WIDTH-1:0] in_second_z,
  input  logic                          in_last_pair,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [16:0]                   out_tm_score,
  output logic [15:0]                   out_pair_count
);

  localparam int CW    = COORD_WIDTH;
  localparam int ACC_W = CW + ROT_W + 2;
  localparam int DF_W  = ACC_W + 2;
  localparam int PR_W  = 2 * MUL_W;

  logic [3*ROT_W-1:0]   rot_r [3];
  logic [CFG_DATA_W-1:0] trans_r;
  logic [15:0]          dscale_r, norm_r;

  logic signed [CW-1:0] ref_r [3];
  logic signed [CW-1:0] part_r [3];
  logic                 last_r;

  logic signed [ACC_W-1:0] acc_r;
  logic signed [PR_W-1:0]  prod_r;
  logic [30:0]             abs_r;
  logic [DIV_W-1:0]        d_r;
  logic [31:0]             sum_r;
  logic [15:0]             pairs_r;
  logic                    out_valid_r;
  logic [16:0]             score_r;
  logic [15:0]             count_r;

  logic [3*ROT_W-1:0]      row_w;
  logic signed [ROT_W-1:0] entry;
  logic signed [CW-1:0]    part_sel, ref_sel;
  logic signed [TRANS_W-1:0] trans_sel;
  logic signed [MUL_W-1:0] op_a, op_b;
  logic signed [ACC_W-1:0] rnd;
  logic signed [DF_W-1:0]  diff, mag;
  logic [DIV_W-1:0]        den_t, num_t, num_f, den_f, div_num, div_den;
  logic [15:0]             norm_eff;
  logic                    div_done;
  logic [16:0]             quo;
  logic [32:0]             sum_add;

  always_comb begin
    row_w = rot_r[cmd.row];
    case (cmd.col)
      2'd0:    entry = signed'(row_w[ROT_W-1:0]);
      2'd1:    entry = signed'(row_w[2*ROT_W-1:ROT_W]);
      default: entry = signed'(row_w[3*ROT_W-1:2*ROT_W]);
    endcase
    case (cmd.col)
      2'd0:    part_sel = part_r[0];
      2'd1:    part_sel = part_r[1];
      default: part_sel = part_r[2];
    endcase
    case (cmd.row)
      2'd0: begin
        ref_sel   = ref_r[0];
        trans_sel = signed'(trans_r[TRANS_W-1:0]);
      end
      2'd1: begin
        ref_sel   = ref_r[1];
        trans_sel = signed'(trans_r[2*TRANS_W-1:TRANS_W]);
      end
      default: begin
        ref_sel   = ref_r[2];
        trans_sel = signed'(trans_r[3*TRANS_W-1:2*TRANS_W]);
      end
    endcase
  end

  always_comb begin
    case (cmd.mul_sel)
      MS_ROT: begin
        op_a = MUL_W'(entry);
        op_b = MUL_W'(part_sel);
      end
      MS_SQ: begin
        op_a = signed'({2'b00, abs_r});
        op_b = signed'({2'b00, abs_r});
      end
      default: begin
        op_a = signed'({17'd0, dscale_r});
        op_b = signed'({17'd0, dscale_r});
      end
    endcase
  end

  // round half up from Q.16 to whole coordinate units, translate, difference, clamped magnitude
  assign rnd  = (acc_r + ACC_W'(32768)) >>> 16;
  assign diff = DF_W'(ref_sel) - (DF_W'(rnd) + DF_W'(trans_sel));
  assign mag  = diff[DF_W-1] ? -diff : diff;

  assign den_t    = prod_r[DIV_W-1:0] + d_r;
  assign num_t    = {16'd0, prod_r[31:0], 16'd0} + (den_t >> 1);
  assign norm_eff = (norm_r == 16'd0) ? 16'd1 : norm_r;
  assign den_f    = {48'd0, norm_eff};
  assign num_f    = {32'd0, sum_r} + {49'd0, norm_eff[15:1]};
  assign div_num  = cmd.div_final ? num_f : num_t;
  assign div_den  = cmd.div_final ? den_f : den_t;

  tmsa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  assign sum_add = {1'b0, sum_r} + {16'd0, quo};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0] <= 54'd65536;
      rot_r[1] <= 54'd4294967296;
      rot_r[2] <= 54'd281474976710656;
      trans_r  <= '0;
      dscale_r <= 16'd1280;
      norm_r   <= 16'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ROT_X:  rot_r[0] <= cfg_data[3*ROT_W-1:0];
        CFG_ROT_Y:  rot_r[1] <= cfg_data[3*ROT_W-1:0];
        CFG_ROT_Z:  rot_r[2] <= cfg_data[3*ROT_W-1:0];
        CFG_TRANS:  trans_r  <= cfg_data;
        CFG_DSCALE: dscale_r <= cfg_data[15:0];
        CFG_NORM:   norm_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ref_r[0]  <= in_first_x;
      ref_r[1]  <= in_first_y;
      ref_r[2]  <= in_first_z;
      part_r[0] <= in_second_x;
      part_r[1] <= in_second_y;
      part_r[2] <= in_second_z;
      last_r    <= in_last_pair;
    end
    if (cmd.mul_en) begin
      prod_r <= op_a * op_b;
    end
    if (cmd.load || cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_en) begin
      acc_r <= acc_r + prod_r[ACC_W-1:0];
    end
    if (cmd.diff_en) begin
      abs_r <= (mag > DF_W'(32'h7fffffff)) ? 31'h7fffffff : mag[30:0];
    end
    if (cmd.load) begin
      d_r <= '0;
    end else if (cmd.dadd_en) begin
      d_r <= d_r + prod_r[DIV_W-1:0];
    end
    if (cmd.out_load) begin
      score_r <= quo;
      count_r <= pairs_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      pairs_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        sum_r   <= '0;
        pairs_r <= '0;
      end else if (cmd.sum_en) begin
        sum_r   <= sum_add[32] ? 32'hffffffff : sum_add[31:0];
        pairs_r <= (pairs_r == 16'hffff) ? pairs_r : pairs_r + 16'd1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.div_done = div_done;
  assign status.last     = last_r;
  assign status.out_busy = out_valid_r && out_stall;

  assign out_valid      = out_valid_r;
  assign out_tm_score   = score_r;
  assign out_pair_count = count_r;

  `TMSA_ASSERT_NOW(a_no_overwrite, cmd.out_load, !(out_valid_r && out_stall), "result overwritten")
  `TMSA_ASSERT_NOW(a_score_range, out_valid_r, out_tm_score <= ONE_Q16, "score above one")

endmodule

/* hdl/tmsa_ctrl.sv */
// controller: sequences multiplies, divisions and result delivery
module tmsa_ctrl
  import tmsa_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t     state_r, state_nxt;
  logic [1:0] row_r, row_nxt, col_r, col_nxt;

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_MUL;
          row_nxt   = 2'd0;
          col_nxt   = 2'd0;
        end
      end
      ST_MUL: state_nxt = ST_ACC;
      ST_ACC: begin
        if (col_r == 2'd2) begin
          state_nxt = ST_DIFF;
        end else begin
          col_nxt   = col_r + 2'd1;
          state_nxt = ST_MUL;
        end
      end
      ST_DIFF: state_nxt = ST_SQ;
      ST_SQ:   state_nxt = ST_DADD;
      ST_DADD: begin
        col_nxt = 2'd0;
        if (row_r == 2'd2) begin
          state_nxt = ST_D0;
        end else begin
          row_nxt   = row_r + 2'd1;
          state_nxt = ST_MUL;
        end
      end
      ST_D0:   state_nxt = ST_DEN;
      ST_DEN:  state_nxt = ST_TDIV;
      ST_TDIV: if (status.div_done) state_nxt = ST_SUM;
      ST_SUM:  state_nxt = status.last ? ST_FST : ST_IDLE;
      ST_FST:  state_nxt = ST_FDIV;
      ST_FDIV: if (status.div_done) state_nxt = ST_OUT;
      ST_OUT:  if (!status.out_busy) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = MS_ROT;
    cmd.row     = row_r;
    cmd.col     = col_r;
    in_stall    = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_MUL:  cmd.mul_en = 1'b1;
      ST_ACC:  cmd.acc_en = 1'b1;
      ST_DIFF: begin
        cmd.diff_en = 1'b1;
        cmd.acc_clr = 1'b1;
      end
      ST_SQ: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_SQ;
      end
      ST_DADD: cmd.dadd_en = 1'b1;
      ST_D0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_D0;
      end
      ST_DEN:  cmd.div_start = 1'b1;
      ST_SUM:  cmd.sum_en = 1'b1;
      ST_FST: begin
        cmd.div_start = 1'b1;
        cmd.div_final = 1'b1;
      end
      ST_OUT:  cmd.out_load = !status.out_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    col_r <= col_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
